// ----- rtl/esm_pkg.sv -----
// ----------------------------------------------------------------------------
// Encoder speed measurement package
// Shared widths, reset values, codes and types for the speed measurement block.
// ----------------------------------------------------------------------------
package esm_pkg;

    localparam int CNT_W    = 32;
    localparam int TIME_W   = 64;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_W    = 84;
    localparam int DEN_W    = 80;
    localparam int QUO_W    = 32;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W   = $clog2(DIV_STEPS + 1);

    localparam logic [15:0] CALC_INTERVAL_RST = 16'd10;
    localparam logic [15:0] PPR_RST           = 16'd1024;
    localparam logic [31:0] TIMER_HZ_RST      = 32'd240000000;
    localparam logic [31:0] US_PER_SEC        = 32'd1000000;
    localparam logic [31:0] SPEED_MAX         = 32'h7FFF_FFFF;
    localparam logic [31:0] SPEED_MIN         = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_CALC_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_HZ      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_S,
        ST_MUL_D0,
        ST_MUL_D1,
        ST_ADD_D,
        ST_SPD_GO,
        ST_SPD_WAIT,
        ST_MUL_I0,
        ST_MUL_I1,
        ST_ADD_I,
        ST_INT_GO,
        ST_INT_WAIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/esm_div.sv -----
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Produces a 32-bit quotient one bit per cycle, saturated to all ones when the
// true quotient does not fit.
// ----------------------------------------------------------------------------
module esm_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [esm_pkg::NUM_W-1:0]  num,
    input  logic [esm_pkg::DEN_W-1:0]  den,
    output esm_pkg::div_stat_t         stat,
    output logic [esm_pkg::QUO_W-1:0]  quo
);

    logic [esm_pkg::DEN_W-1:0]   rem_reg;
    logic [esm_pkg::DEN_W-1:0]   den_reg;
    logic [esm_pkg::QUO_W-1:0]   quo_reg;
    logic [esm_pkg::STEP_W-1:0]  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic                        ovf;
    logic [esm_pkg::DEN_W+1:0]   trial;

    assign ovf   = {{(esm_pkg::DEN_W - esm_pkg::NUM_W + esm_pkg::QUO_W){1'b0}},
                    num[esm_pkg::NUM_W-1:esm_pkg::QUO_W]} >= den;
    assign trial = {1'b0, rem_reg, quo_reg[esm_pkg::QUO_W-1]} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (ovf)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= esm_pkg::STEP_W'(esm_pkg::DIV_STEPS);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == esm_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            if (ovf)
            begin
                quo_reg <= '1;
            end
            else
            begin
                rem_reg <= {{(esm_pkg::DEN_W - esm_pkg::NUM_W + esm_pkg::QUO_W){1'b0}},
                            num[esm_pkg::NUM_W-1:esm_pkg::QUO_W]};
                quo_reg <= num[esm_pkg::QUO_W-1:0];
            end
        end
        else if (busy_reg)
        begin
            if (!trial[esm_pkg::DEN_W+1])
            begin
                rem_reg <= trial[esm_pkg::DEN_W-1:0];
            end
            else
            begin
                rem_reg <= {rem_reg[esm_pkg::DEN_W-2:0], quo_reg[esm_pkg::QUO_W-1]};
            end
            quo_reg <= {quo_reg[esm_pkg::QUO_W-2:0], ~trial[esm_pkg::DEN_W+1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

// ----- rtl/encoder_speed_measure.sv -----
// ----------------------------------------------------------------------------
// Encoder speed measurement
// Counts periodic calls and, every calc_interval calls, measures encoder speed
// in signed Q15.16 rev/s and the elapsed interval in microseconds.
// ----------------------------------------------------------------------------
// Each transaction on the input channel yields exactly one result transaction.
// A restart or a periodic call that does not compute goes from the idle state
// straight to the response state, where its result is loaded. For a computing
// call a single 32x32 multiplier builds the operands of each division, and one
// shared restoring divider runs two divisions, first one for the speed and then
// one for the interval. A division whose quotient does not fit in 32 bits ends
// at once. A zero elapsed time skips both and goes from the preparation state
// straight to the response state. The response state also waits for the output
// register to free up. The input is not ready while a call is being worked on,
// but a new call is accepted while the previous result still waits on the
// output.
module encoder_speed_measure
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [esm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [esm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic signed [31:0]            encoder_count,
    input  logic [63:0]                   time_now,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            speed_q16,
    output logic [31:0]                   interval_us,
    output logic                          updated,
    output logic                          divide_fault
);

    esm_pkg::state_t state_reg, state_next;

    logic [15:0] calc_interval_reg;
    logic [15:0] ppr_reg;
    logic [31:0] hz_reg;
    logic [15:0] call_counter_reg;
    logic [15:0] call_counter_next;
    logic [31:0] prior_count_reg;
    logic [63:0] prior_time_reg;
    logic [31:0] held_speed_reg;
    logic [31:0] held_interval_reg;
    logic        upd_flag_reg;
    logic        fault_flag_reg;
    logic        out_valid_reg;

    logic [31:0] diff_reg;
    logic [63:0] ticks_reg;
    logic [31:0] mag_reg;
    logic        neg_reg;
    logic [63:0] prod_reg;
    logic [esm_pkg::NUM_W-1:0] num_reg;
    logic [esm_pkg::DEN_W-1:0] den_reg;
    logic [31:0] speed_out_reg;
    logic [31:0] interval_out_reg;
    logic        updated_out_reg;
    logic        fault_out_reg;

    logic [15:0] ppr_eff;
    logic [31:0] hz_eff;
    logic        calc_hit;
    logic        ticks_zero;
    logic        out_free;
    logic        div_start;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] speed_limit;
    logic [31:0] speed_mag;
    logic [31:0] fault_speed;
    logic [31:0] div_quo;
    esm_pkg::div_stat_t div_stat;

    assign ppr_eff           = (ppr_reg == '0) ? 16'd1 : ppr_reg;
    assign hz_eff            = (hz_reg == '0) ? 32'd1 : hz_reg;
    assign call_counter_next = call_counter_reg + 16'd1;
    assign calc_hit          = call_counter_next >= calc_interval_reg;
    assign ticks_zero        = ticks_reg == '0;
    assign out_free          = !out_valid_reg || out_ready;
    assign speed_limit       = neg_reg ? esm_pkg::SPEED_MIN : esm_pkg::SPEED_MAX;
    assign speed_mag         = (div_quo > speed_limit) ? speed_limit : div_quo;
    assign fault_speed       = (diff_reg == '0) ? 32'd0 :
                               (diff_reg[31] ? esm_pkg::SPEED_MIN : esm_pkg::SPEED_MAX);

    esm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= esm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        in_ready   = 1'b0;
        mul_a      = mag_reg;
        mul_b      = hz_eff;
        case (state_reg)
            esm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = (!action && calc_hit) ? esm_pkg::ST_PREP : esm_pkg::ST_RESP;
                end
            end
            esm_pkg::ST_PREP:
            begin
                state_next = ticks_zero ? esm_pkg::ST_RESP : esm_pkg::ST_MUL_S;
            end
            esm_pkg::ST_MUL_S:
            begin
                state_next = esm_pkg::ST_MUL_D0;
            end
            esm_pkg::ST_MUL_D0:
            begin
                mul_a      = {16'd0, ppr_eff};
                mul_b      = ticks_reg[31:0];
                state_next = esm_pkg::ST_MUL_D1;
            end
            esm_pkg::ST_MUL_D1:
            begin
                mul_a      = {16'd0, ppr_eff};
                mul_b      = ticks_reg[63:32];
                state_next = esm_pkg::ST_ADD_D;
            end
            esm_pkg::ST_ADD_D:
            begin
                state_next = esm_pkg::ST_SPD_GO;
            end
            esm_pkg::ST_SPD_GO:
            begin
                div_start  = 1'b1;
                state_next = esm_pkg::ST_SPD_WAIT;
            end
            esm_pkg::ST_SPD_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = esm_pkg::ST_MUL_I0;
                end
            end
            esm_pkg::ST_MUL_I0:
            begin
                mul_a      = ticks_reg[31:0];
                mul_b      = esm_pkg::US_PER_SEC;
                state_next = esm_pkg::ST_MUL_I1;
            end
            esm_pkg::ST_MUL_I1:
            begin
                mul_a      = ticks_reg[63:32];
                mul_b      = esm_pkg::US_PER_SEC;
                state_next = esm_pkg::ST_ADD_I;
            end
            esm_pkg::ST_ADD_I:
            begin
                state_next = esm_pkg::ST_INT_GO;
            end
            esm_pkg::ST_INT_GO:
            begin
                div_start  = 1'b1;
                state_next = esm_pkg::ST_INT_WAIT;
            end
            esm_pkg::ST_INT_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = esm_pkg::ST_RESP;
                end
            end
            esm_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = esm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = esm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_interval_reg <= esm_pkg::CALC_INTERVAL_RST;
            ppr_reg           <= esm_pkg::PPR_RST;
            hz_reg            <= esm_pkg::TIMER_HZ_RST;
            call_counter_reg  <= '0;
            prior_count_reg   <= '0;
            prior_time_reg    <= '0;
            held_speed_reg    <= '0;
            held_interval_reg <= '0;
            upd_flag_reg      <= 1'b0;
            fault_flag_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    esm_pkg::CFG_CALC_INTERVAL:  calc_interval_reg <= cfg_data[15:0];
                    esm_pkg::CFG_PULSES_PER_REV: ppr_reg <= cfg_data[15:0];
                    esm_pkg::CFG_TIMER_HZ:       hz_reg <= cfg_data;
                    default:                     ;
                endcase
            end

            case (state_reg)
                esm_pkg::ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        fault_flag_reg <= 1'b0;
                        if (action)
                        begin
                            prior_count_reg <= '0;
                            held_speed_reg  <= '0;
                            prior_time_reg  <= time_now;
                            upd_flag_reg    <= 1'b0;
                        end
                        else
                        begin
                            call_counter_reg <= calc_hit ? 16'd0 : call_counter_next;
                            upd_flag_reg     <= calc_hit;
                            if (calc_hit)
                            begin
                                prior_count_reg <= $unsigned(encoder_count);
                                prior_time_reg  <= time_now;
                            end
                        end
                    end
                end
                esm_pkg::ST_PREP:
                begin
                    if (ticks_zero)
                    begin
                        fault_flag_reg    <= 1'b1;
                        held_speed_reg    <= fault_speed;
                        held_interval_reg <= '0;
                    end
                end
                esm_pkg::ST_SPD_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        held_speed_reg <= neg_reg ? (32'd0 - speed_mag) : speed_mag;
                    end
                end
                esm_pkg::ST_INT_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        held_interval_reg <= div_quo;
                    end
                end
                default:
                begin
                end
            endcase

            if (state_reg == esm_pkg::ST_RESP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            esm_pkg::ST_IDLE:
            begin
                diff_reg  <= $unsigned(encoder_count) - prior_count_reg;
                ticks_reg <= time_now - prior_time_reg;
            end
            esm_pkg::ST_PREP:
            begin
                neg_reg <= diff_reg[31];
                mag_reg <= diff_reg[31] ? (32'd0 - diff_reg) : diff_reg;
            end
            esm_pkg::ST_MUL_D0:
            begin
                num_reg <= {4'd0, prod_reg, 16'd0};
            end
            esm_pkg::ST_MUL_D1:
            begin
                den_reg <= {16'd0, prod_reg};
            end
            esm_pkg::ST_ADD_D:
            begin
                den_reg <= den_reg + {prod_reg[47:0], 32'd0};
            end
            esm_pkg::ST_MUL_I1:
            begin
                num_reg <= {20'd0, prod_reg};
            end
            esm_pkg::ST_ADD_I:
            begin
                num_reg <= num_reg + {prod_reg[51:0], 32'd0};
                den_reg <= {48'd0, hz_eff};
            end
            default:
            begin
            end
        endcase

        if (state_reg == esm_pkg::ST_RESP && out_free)
        begin
            speed_out_reg    <= held_speed_reg;
            interval_out_reg <= held_interval_reg;
            updated_out_reg  <= upd_flag_reg;
            fault_out_reg    <= fault_flag_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign speed_q16    = $signed(speed_out_reg);
    assign interval_us  = interval_out_reg;
    assign updated      = updated_out_reg;
    assign divide_fault = fault_out_reg;

endmodule

// ----- rtl/esm_checker.sv -----
// ----------------------------------------------------------------------------
// Encoder speed measurement checker
// Port-level checks on the speed measurement block, bound to its top level.
// ----------------------------------------------------------------------------
module esm_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [31:0]            speed_q16,
    input logic [31:0]                   interval_us,
    input logic                          updated,
    input logic                          divide_fault
);

    // Every transaction keeps the input closed for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    // A fault is only reported by a call that computed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_fault |-> updated)
        else $error("fault without computation");

    // A zero elapsed time reports a zero interval.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_fault |-> interval_us == 32'd0)
        else $error("fault with nonzero interval");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(speed_q16)
            && $stable(interval_us) && $stable(updated) && $stable(divide_fault))
        else $error("stalled result changed");

endmodule

bind encoder_speed_measure esm_checker u_esm_checker (.*);

// ----- bench/encoder_speed_measure_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoder speed measurement testbench
// Drives periodic and restart calls through the valid/ready input channel,
// predicts every result transaction with an exact wide-integer model of the
// speed and interval arithmetic, and checks each result field by field.
// A directed plan covers reset values, saturation, zero elapsed time, count
// and timestamp wrap and register extremes; random phases then vary the
// registers and the idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic ACT_CALL    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;
    localparam int   PHASES      = 8;
    localparam int   PHASE_CALLS = 250;

    typedef struct packed {
        logic [31:0] speed;
        logic [31:0] interval;
        logic        updated;
        logic        fault;
    } speed_result_t;

    typedef enum logic {ROW_SETTING, ROW_CALL} row_kind_t;

    typedef struct packed {
        row_kind_t                     kind;
        logic [esm_pkg::CFG_IDX_W-1:0] index;
        logic [esm_pkg::CFG_W-1:0]     value;
        logic                          act;
        logic [31:0]                   count;
        logic [63:0]                   stamp;
        logic                          typed;
        speed_result_t                 want;
    } plan_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [esm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [esm_pkg::CFG_W-1:0]     cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic                          action;
    logic signed [31:0]            encoder_count;
    logic [63:0]                   time_now;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [31:0]            speed_q16;
    logic [31:0]                   interval_us;
    logic                          updated;
    logic                          divide_fault;

    logic [15:0] set_interval = esm_pkg::CALC_INTERVAL_RST;
    logic [15:0] set_ppr      = esm_pkg::PPR_RST;
    logic [31:0] set_hz       = esm_pkg::TIMER_HZ_RST;
    logic [15:0] calls_since  = '0;
    logic [31:0] base_count   = '0;
    logic [63:0] base_time    = '0;
    logic [31:0] speed_hold   = '0;
    logic [31:0] interval_hold = '0;

    logic [31:0] trail_count;
    logic [63:0] trail_time;

    speed_result_t speed_reports_due[$];
    plan_row_t     plan[$];

    int idle_pct;
    int stall_pct;
    int errors;
    int calls_sent;
    int restarts_sent;
    int updates_seen;
    int faults_seen;
    int writes_done;

    encoder_speed_measure dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .encoder_count(encoder_count),
        .time_now     (time_now),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .speed_q16    (speed_q16),
        .interval_us  (interval_us),
        .updated      (updated),
        .divide_fault (divide_fault)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic speed_result_t predict_call(input logic act, input logic [31:0] cnt,
                                                   input logic [63:0] stamp);
        speed_result_t r;
        logic [31:0]   diff;
        logic [31:0]   mag;
        logic [63:0]   ticks;
        logic [31:0]   ppr_eff;
        logic [31:0]   hz_eff;
        logic [127:0]  num;
        logic [127:0]  den;
        logic [127:0]  quo;
        logic [127:0]  lim;
        r = '0;
        if (act == ACT_RESTART)
        begin
            base_count = '0;
            speed_hold = '0;
            base_time  = stamp;
        end
        else
        begin
            calls_since = calls_since + 16'd1;
            if (calls_since >= set_interval)
            begin
                diff    = cnt - base_count;
                mag     = diff[31] ? -diff : diff;
                ticks   = stamp - base_time;
                ppr_eff = (set_ppr == '0) ? 32'd1 : {16'd0, set_ppr};
                hz_eff  = (set_hz == '0) ? 32'd1 : set_hz;
                if (ticks == '0)
                begin
                    r.fault       = 1'b1;
                    speed_hold    = (mag == '0) ? 32'd0 :
                                    (diff[31] ? esm_pkg::SPEED_MIN : esm_pkg::SPEED_MAX);
                    interval_hold = '0;
                end
                else
                begin
                    num = (128'(mag) * 128'(hz_eff)) << 16;
                    den = 128'(ppr_eff) * 128'(ticks);
                    quo = num / den;
                    lim = diff[31] ? 128'(esm_pkg::SPEED_MIN) : 128'(esm_pkg::SPEED_MAX);
                    if (quo > lim)
                    begin
                        quo = lim;
                    end
                    speed_hold = diff[31] ? -quo[31:0] : quo[31:0];
                    quo = (128'(ticks) * 128'(esm_pkg::US_PER_SEC)) / 128'(hz_eff);
                    interval_hold = (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
                end
                base_count  = cnt;
                base_time   = stamp;
                calls_since = '0;
                r.updated   = 1'b1;
            end
        end
        r.speed    = speed_hold;
        r.interval = interval_hold;
        return r;
    endfunction

    function automatic plan_row_t setting_row(input logic [esm_pkg::CFG_IDX_W-1:0] idx,
                                              input logic [esm_pkg::CFG_W-1:0] val);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_SETTING;
        r.index = idx;
        r.value = val;
        return r;
    endfunction

    function automatic plan_row_t call_row(input logic act, input logic [31:0] cnt,
                                           input logic [63:0] stamp);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_CALL;
        r.act   = act;
        r.count = cnt;
        r.stamp = stamp;
        return r;
    endfunction

    function automatic plan_row_t typed_row(input logic act, input logic [31:0] cnt,
                                            input logic [63:0] stamp, input logic [31:0] spd,
                                            input logic [31:0] ivl, input logic upd,
                                            input logic flt);
        plan_row_t r;
        r               = call_row(act, cnt, stamp);
        r.typed         = 1'b1;
        r.want.speed    = spd;
        r.want.interval = ivl;
        r.want.updated  = upd;
        r.want.fault    = flt;
        return r;
    endfunction

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (speed_reports_due.size() != 0);
    endtask

    task automatic write_setting(input logic [esm_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [esm_pkg::CFG_W-1:0] val);
        if (in_valid || speed_reports_due.size() != 0)
        begin
            settle();
        end
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            esm_pkg::CFG_CALC_INTERVAL:  set_interval = val[15:0];
            esm_pkg::CFG_PULSES_PER_REV: set_ppr      = val[15:0];
            esm_pkg::CFG_TIMER_HZ:       set_hz       = val;
            default:                     ;
        endcase
        writes_done++;
    endtask

    task automatic send_call(input logic act, input logic [31:0] cnt, input logic [63:0] stamp,
                             input logic typed, input speed_result_t want);
        speed_result_t predicted;
        cfg_we <= 1'b0;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        encoder_count <= cnt;
        time_now      <= stamp;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_call(act, cnt, stamp);
        speed_reports_due.push_back(typed ? want : predicted);
        calls_sent++;
        if (act == ACT_RESTART)
        begin
            restarts_sent++;
        end
    endtask

    task automatic send_random_call();
        logic        act;
        logic [31:0] delta;
        logic [63:0] step;
        act = ACT_CALL;
        case ($urandom_range(3))
            0:       delta = $urandom_range(200) - 100;
            1:       delta = $urandom_range(131072) - 65536;
            2:       delta = $urandom;
            default: delta = '0;
        endcase
        case ($urandom_range(3))
            0:       step = 64'($urandom_range(1000));
            1:       step = 64'($urandom_range(1 << 20));
            2:       step = {32'd0, $urandom};
            default: step = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        if ($urandom_range(29) == 0)
        begin
            step = '0;
        end
        trail_count = trail_count + delta;
        trail_time  = trail_time + step;
        if ($urandom_range(9) == 0)
        begin
            trail_count = $urandom;
            trail_time  = {$urandom, $urandom};
        end
        if ($urandom_range(19) == 0)
        begin
            act = ACT_RESTART;
        end
        send_call(act, trail_count, trail_time, 1'b0, '0);
    endtask

    task automatic set_pressure(input int mode);
        case (mode % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 83; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 83; end
            default: begin idle_pct = 22; stall_pct = 22; end
        endcase
    endtask

    task automatic check_result();
        speed_result_t want;
        if (speed_reports_due.size() == 0)
        begin
            $error("result transaction with no call pending: speed_q16=%0d", speed_q16);
            errors++;
        end
        else
        begin
            want = speed_reports_due.pop_front();
            if (speed_q16 !== $signed(want.speed))
            begin
                $error("speed_q16 mismatch: expected %0d, actual %0d",
                       $signed(want.speed), speed_q16);
                errors++;
            end
            if (interval_us !== want.interval)
            begin
                $error("interval_us mismatch: expected %0d, actual %0d",
                       want.interval, interval_us);
                errors++;
            end
            if (updated !== want.updated)
            begin
                $error("updated mismatch: expected %0b, actual %0b", want.updated, updated);
                errors++;
            end
            if (divide_fault !== want.fault)
            begin
                $error("divide_fault mismatch: expected %0b, actual %0b",
                       want.fault, divide_fault);
                errors++;
            end
            if (want.updated)
            begin
                updates_seen++;
            end
            if (want.fault)
            begin
                faults_seen++;
            end
        end
    endtask

    task automatic load_plan();
        plan.push_back(typed_row(ACT_RESTART, 32'd5, 64'd100, 32'd0, 32'd0, 1'b0, 1'b0));
        plan.push_back(typed_row(ACT_CALL, 32'd7, 64'd200, 32'd0, 32'd0, 1'b0, 1'b0));
        plan.push_back(setting_row(esm_pkg::CFG_CALC_INTERVAL, 32'd1));
        plan.push_back(setting_row(esm_pkg::CFG_PULSES_PER_REV, 32'd1));
        plan.push_back(setting_row(esm_pkg::CFG_TIMER_HZ, 32'd1000000));
        plan.push_back(typed_row(ACT_CALL, 32'd1000, 64'd1100, esm_pkg::SPEED_MAX, 32'd1000,
                                 1'b1, 1'b0));
        plan.push_back(typed_row(ACT_CALL, 32'd2000, 64'd1100, esm_pkg::SPEED_MAX, 32'd0,
                                 1'b1, 1'b1));
        plan.push_back(typed_row(ACT_CALL, 32'd0, 64'd1100, esm_pkg::SPEED_MIN, 32'd0,
                                 1'b1, 1'b1));
        plan.push_back(typed_row(ACT_CALL, 32'd0, 64'd1100, 32'd0, 32'd0, 1'b1, 1'b1));
        plan.push_back(typed_row(ACT_CALL, 32'd1, 64'd1001100, 32'd65536, 32'd1000000,
                                 1'b1, 1'b0));
        plan.push_back(typed_row(ACT_CALL, 32'd0, 64'd2001100, 32'hFFFF_0000, 32'd1000000,
                                 1'b1, 1'b0));
        plan.push_back(call_row(ACT_CALL, 32'h7FFF_FFFF, 64'd2001101));
        plan.push_back(call_row(ACT_CALL, 32'h8000_0000, 64'd3001101));
        plan.push_back(call_row(ACT_CALL, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(call_row(ACT_CALL, 32'hFFFF_FFFF, 64'd999));
        plan.push_back(typed_row(ACT_CALL, 32'hFFFF_FFFF, 64'h8000_0000_0000_03E7, 32'd0,
                                 32'hFFFF_FFFF, 1'b1, 1'b0));
        plan.push_back(typed_row(ACT_RESTART, 32'd123, 64'd500, 32'd0, 32'hFFFF_FFFF,
                                 1'b0, 1'b0));
        plan.push_back(setting_row(esm_pkg::CFG_CALC_INTERVAL, 32'd0));
        plan.push_back(setting_row(esm_pkg::CFG_PULSES_PER_REV, 32'd65535));
        plan.push_back(setting_row(esm_pkg::CFG_TIMER_HZ, 32'hFFFF_FFFF));
        plan.push_back(call_row(ACT_CALL, 32'h7FFF_FFFF, 64'd501));
        plan.push_back(call_row(ACT_CALL, 32'h8000_0001, 64'h1_0000_01F5));
        plan.push_back(setting_row(esm_pkg::CFG_PULSES_PER_REV, 32'd0));
        plan.push_back(setting_row(esm_pkg::CFG_TIMER_HZ, 32'd0));
        plan.push_back(call_row(ACT_CALL, 32'd12345, 64'h1_0000_01FC));
        plan.push_back(call_row(ACT_CALL, 32'hFFFF_FFFB, 64'h1_0000_01FC + 64'd1000000));
        plan.push_back(setting_row(esm_pkg::CFG_CALC_INTERVAL, 32'd3));
        plan.push_back(setting_row(esm_pkg::CFG_PULSES_PER_REV, 32'd1000));
        plan.push_back(setting_row(esm_pkg::CFG_TIMER_HZ, 32'd240000000));
        plan.push_back(call_row(ACT_CALL, 32'd10, 64'h2_0000_0000));
        plan.push_back(call_row(ACT_CALL, 32'd20, 64'h2_0000_0000 + 64'd240000));
        plan.push_back(call_row(ACT_CALL, 32'd30, 64'h2_0000_0000 + 64'd480000));
        plan.push_back(setting_row(esm_pkg::CFG_CALC_INTERVAL, 32'd65535));
        plan.push_back(call_row(ACT_CALL, 32'd40, 64'h2_0000_0000 + 64'd720000));
        plan.push_back(call_row(ACT_CALL, 32'd50, 64'h2_0000_0000 + 64'd960000));
        plan.push_back(call_row(ACT_RESTART, 32'd0, 64'd0));
    endtask

    task automatic configure_phase(input int p);
        case (p)
            0:
            begin
                write_setting(esm_pkg::CFG_CALC_INTERVAL, 32'(esm_pkg::CALC_INTERVAL_RST));
                write_setting(esm_pkg::CFG_PULSES_PER_REV, 32'(esm_pkg::PPR_RST));
                write_setting(esm_pkg::CFG_TIMER_HZ, esm_pkg::TIMER_HZ_RST);
            end
            1:
            begin
                write_setting(esm_pkg::CFG_CALC_INTERVAL, 32'd1);
                write_setting(esm_pkg::CFG_PULSES_PER_REV, 32'd1);
                write_setting(esm_pkg::CFG_TIMER_HZ, 32'd1);
            end
            2:
            begin
                write_setting(esm_pkg::CFG_CALC_INTERVAL, 32'd2);
                write_setting(esm_pkg::CFG_PULSES_PER_REV, 32'd65535);
                write_setting(esm_pkg::CFG_TIMER_HZ, 32'hFFFF_FFFF);
            end
            3:
            begin
                write_setting(esm_pkg::CFG_CALC_INTERVAL, 32'd0);
                write_setting(esm_pkg::CFG_PULSES_PER_REV, $urandom_range(65535, 1));
                write_setting(esm_pkg::CFG_TIMER_HZ, $urandom);
            end
            default:
            begin
                write_setting(esm_pkg::CFG_CALC_INTERVAL, $urandom_range(5, 1));
                write_setting(esm_pkg::CFG_PULSES_PER_REV, $urandom_range(65535, 1));
                if ($urandom_range(1) == 0)
                begin
                    write_setting(esm_pkg::CFG_TIMER_HZ, $urandom_range(100000000, 1000));
                end
                else
                begin
                    write_setting(esm_pkg::CFG_TIMER_HZ, $urandom);
                end
            end
        endcase
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                check_result();
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #3000000;
        $display("encoder_speed_measure verification failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        action        = ACT_CALL;
        encoder_count = '0;
        time_now      = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        errors        = 0;
        calls_sent    = 0;
        restarts_sent = 0;
        updates_seen  = 0;
        faults_seen   = 0;
        writes_done   = 0;
        trail_count   = '0;
        trail_time    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_plan();
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_SETTING)
            begin
                write_setting(plan[i].index, plan[i].value);
            end
            else
            begin
                send_call(plan[i].act, plan[i].count, plan[i].stamp, plan[i].typed,
                          plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            set_pressure(p);
            configure_phase(p);
            for (int n = 0; n < PHASE_CALLS; n++)
            begin
                send_random_call();
            end
        end

        settle();
        repeat (100) @(posedge clk);
        $display("Ran %0d calls (%0d restarts) with %0d register writes over %0d phases.",
                 calls_sent, restarts_sent, writes_done, PHASES);
        $display("Saw %0d speed updates, %0d of them with zero elapsed time.",
                 updates_seen, faults_seen);
        if (errors == 0)
        begin
            $display("encoder_speed_measure verification clean");
        end
        else
        begin
            $display("encoder_speed_measure verification failed");
        end
        $finish;
    end

endmodule

// ----- encoder_speed_measure.f -----
rtl/esm_pkg.sv
rtl/esm_div.sv
rtl/encoder_speed_measure.sv
rtl/esm_checker.sv
bench/encoder_speed_measure_tb.sv
